// File: rtl/sfcc_pkg.sv
// Shared constants and helper functions for the sensor frame CRC and scaling block.
// Holds the CRC-8 routine, the divide-by-full-scale routine and the field widths.
// Depends on nothing; used by sensor_frame_crc_convert.
package sfcc_pkg;

	// Field widths of the frame and the result.
	localparam int RAW_W   = 16;
	localparam int CHK_W   = 8;
	localparam int TEMP_W  = 16;
	localparam int HUMI_W  = 15;
	localparam int S_DATA_W = 2 * RAW_W + 2 * CHK_W;
	localparam int M_DATA_W = 32;
	localparam int M_USER_W = 2;

	// Scale products: raw times span, before the divide by full scale.
	localparam int TPROD_W = 31;
	localparam int HPROD_W = 30;
	localparam int TQ_W    = 15;
	localparam int HQ_W    = 14;

	localparam logic [14:0] TEMP_SPAN_CENTI = 15'd17500;
	localparam logic [13:0] HUMI_SPAN_CENTI = 14'd10000;
	localparam logic [15:0] TEMP_OFFSET_CENTI = 16'd4500;
	localparam logic [16:0] RAW_FULL_SCALE = 17'd65535;

	localparam logic signed [TEMP_W-1:0] TEMP_FAIL_CENTI = -16'sd27315;
	localparam logic signed [HUMI_W-1:0] HUMI_FAIL_CENTI = -15'sd100;

	// CRC-8 settings: polynomial x^8 + x^5 + x^4 + 1, preset to all ones.
	localparam logic [7:0] CRC_POLY = 8'h31;
	localparam logic [7:0] CRC_INIT = 8'hFF;

	// Configuration register map.
	localparam int ADDR_W = 3;
	localparam logic REG_CRC_CHECK_ENABLE = 1'b0;

	// CRC-8 over one 16-bit word, high byte first, bit by bit from the top.
	function automatic logic [7:0] crc8_word(input logic [RAW_W-1:0] word);
		logic [7:0] crc;
		logic       fb;
		crc = CRC_INIT;
		for (int i = RAW_W - 1; i >= 0; i--) begin
			fb  = crc[7] ^ word[i];
			crc = {crc[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
		end
		return crc;
	endfunction

	// Truncating divide by 65535. The estimate x >> 16 is at most one short,
	// because the quotient stays far below 65536; the remainder of the
	// estimate is the low half plus the estimate itself.
	function automatic logic [TQ_W-1:0] div_full_scale(input logic [TPROD_W-1:0] x);
		logic [TQ_W-1:0] q0;
		logic [16:0]     r0;
		q0 = x[TPROD_W-1:16];
		r0 = {1'b0, x[15:0]} + 17'(q0);
		return q0 + TQ_W'(r0 >= RAW_FULL_SCALE);
	endfunction

endpackage

// File: rtl/sensor_frame_crc_convert.sv
// Top level of the sensor frame CRC check and unit conversion block.
// Three-stage pipeline with a stream input, a stream output and an APB register port.
// Depends on sfcc_pkg for constants, the CRC routine and the divide routine.
//
// Channel   Direction  Signals                        Content
// s_*       in         s_tvalid s_tready s_tdata      one six-byte sensor frame
// m_*       out        m_tvalid m_tready m_tdata/user scaled values and ok flags
// apb       in/out     psel penable pwrite paddr ...  crc_check_enable at address 0
//
// One frame is taken per cycle while s_tready is high, and its result is registered in
// the CRC/multiply, divide and offset stages in turn before it appears on the output.
// Reset clears the valid bits and the register; the data registers keep no reset.
// An empty stage always loads, so bubbles close up while the output is stalled;
// s_tready falls only when all three stages hold results and m_tready is low.
module sensor_frame_crc_convert (
	input  logic                          clk,
	input  logic                          arst_n,
	// Frame input: temp_raw [15:0], temp_check [23:16], humi_raw [39:24], humi_check [47:40].
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [sfcc_pkg::S_DATA_W-1:0] s_tdata,
	// Result output: temp_centi [15:0], humi_centi [30:16], zero [31].
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [sfcc_pkg::M_DATA_W-1:0] m_tdata,
	// Result flags: temp_ok [0], humi_ok [1].
	output logic [sfcc_pkg::M_USER_W-1:0] m_tuser,
	// Configuration port.
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [sfcc_pkg::ADDR_W-1:0]   paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);

	// Unpacked input fields.
	logic [sfcc_pkg::RAW_W-1:0] temp_raw;
	logic [sfcc_pkg::CHK_W-1:0] temp_check;
	logic [sfcc_pkg::RAW_W-1:0] humi_raw;
	logic [sfcc_pkg::CHK_W-1:0] humi_check;

	logic crc_check_enable_q;

	logic v_s1, v_s2, v_s3;
	logic en_s1, en_s2, en_s3;

	logic [sfcc_pkg::TPROD_W-1:0] tprod_s1;
	logic [sfcc_pkg::HPROD_W-1:0] hprod_s1;
	logic                         tok_s1, hok_s1;

	logic [sfcc_pkg::TQ_W-1:0] tq_s2;
	logic [sfcc_pkg::HQ_W-1:0] hq_s2;
	logic                      tok_s2, hok_s2;

	logic signed [sfcc_pkg::TEMP_W-1:0] temp_centi_s3;
	logic signed [sfcc_pkg::HUMI_W-1:0] humi_centi_s3;
	logic                               tok_s3, hok_s3;

	logic                      wr_en;
	logic [sfcc_pkg::TQ_W-1:0] hq_wide;

	assign temp_raw   = s_tdata[15:0];
	assign temp_check = s_tdata[23:16];
	assign humi_raw   = s_tdata[39:24];
	assign humi_check = s_tdata[47:40];

	// Register port: one register, written on the access phase.
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite
		&& (paddr[2] == sfcc_pkg::REG_CRC_CHECK_ENABLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_check_enable_q <= 1'b0;
		end else if (wr_en) begin
			crc_check_enable_q <= pwdata[0];
		end
	end

	always_comb begin
		prdata = 32'd0;
		if (paddr[2] == sfcc_pkg::REG_CRC_CHECK_ENABLE) begin
			prdata = {31'd0, crc_check_enable_q};
		end
	end

	// Stage enables: a stage loads when it is empty or its content moves on.
	assign en_s3    = !v_s3 || m_tready;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign s_tready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= s_tvalid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
		end
	end

	// Stage 1: CRC of each word against its check byte, and the scale products.
	always_ff @(posedge clk) begin
		if (en_s1 && s_tvalid) begin
			tok_s1   <= !crc_check_enable_q
				|| (sfcc_pkg::crc8_word(temp_raw) == temp_check);
			hok_s1   <= !crc_check_enable_q
				|| (sfcc_pkg::crc8_word(humi_raw) == humi_check);
			tprod_s1 <= sfcc_pkg::TPROD_W'(temp_raw) * sfcc_pkg::TPROD_W'(sfcc_pkg::TEMP_SPAN_CENTI);
			hprod_s1 <= sfcc_pkg::HPROD_W'(humi_raw) * sfcc_pkg::HPROD_W'(sfcc_pkg::HUMI_SPAN_CENTI);
		end
	end

	// Stage 2: truncating divide of both products by the full-scale count.
	assign hq_wide = sfcc_pkg::div_full_scale(sfcc_pkg::TPROD_W'(hprod_s1));

	always_ff @(posedge clk) begin
		if (en_s2 && v_s1) begin
			tq_s2  <= sfcc_pkg::div_full_scale(tprod_s1);
			hq_s2  <= hq_wide[sfcc_pkg::HQ_W-1:0];
			tok_s2 <= tok_s1;
			hok_s2 <= hok_s1;
		end
	end

	// Stage 3: temperature offset and sentinel substitution; this is the output register.
	always_ff @(posedge clk) begin
		if (en_s3 && v_s2) begin
			temp_centi_s3 <= tok_s2
				? $signed(sfcc_pkg::TEMP_W'(tq_s2) - sfcc_pkg::TEMP_OFFSET_CENTI)
				: sfcc_pkg::TEMP_FAIL_CENTI;
			humi_centi_s3 <= hok_s2 ? $signed(sfcc_pkg::HUMI_W'(hq_s2))
				: sfcc_pkg::HUMI_FAIL_CENTI;
			tok_s3 <= tok_s2;
			hok_s3 <= hok_s2;
		end
	end

	assign m_tvalid = v_s3;
	assign m_tdata  = {1'b0, humi_centi_s3, temp_centi_s3};
	assign m_tuser  = {hok_s3, tok_s3};

	// A failed temperature word carries its sentinel.
	a_temp_sentinel: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && !tok_s3) |-> (temp_centi_s3 == sfcc_pkg::TEMP_FAIL_CENTI))
		else $error("temperature failure without sentinel");

	// A good humidity value lies within the scale.
	a_humi_range: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && hok_s3) |-> (humi_centi_s3 >= 15'sd0 && humi_centi_s3 <= 15'sd10000))
		else $error("humidity value out of range");

	// The input is held off only when every stage is full and the output stalls.
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (v_s1 && v_s2 && v_s3 && !m_tready))
		else $error("input stalled with room in the pipeline");

endmodule

// File: sim/tb.sv
`timescale 1ns / 100ps
// Testbench for sensor_frame_crc_convert: frames go in on the stream input and results
// are checked against a predictor of the CRC-8 check and the unit conversion.
// Depends on sfcc_pkg and the block's RTL; needs no files or arguments.
module tb;

	// One input frame, first field in the lowest bits, as it travels on s_tdata.
	typedef struct packed {
		logic [7:0]  humi_check;
		logic [15:0] humi_raw;
		logic [7:0]  temp_check;
		logic [15:0] temp_raw;
	} frame_t;

	// One converted reading, as carried by m_tdata and m_tuser.
	typedef struct packed {
		logic               humi_ok;
		logic               temp_ok;
		logic signed [14:0] humi_centi;
		logic signed [15:0] temp_centi;
	} reading_t;

	// A row of the directed table; typed rows carry their reading, the rest are predicted.
	typedef struct packed {
		logic     check_on;
		frame_t   frame;
		logic     typed;
		reading_t reading;
	} directed_row_t;

	localparam int unsigned TEMP_SPAN   = 17500;
	localparam int unsigned HUMI_SPAN   = 10000;
	localparam int unsigned FULL_SCALE  = 65535;
	localparam int          TEMP_OFFSET = 4500;
	localparam int          TEMP_FAIL   = -27315;
	localparam int          HUMI_FAIL   = -100;
	localparam logic [7:0]  CRC8_POLY   = 8'h31;
	localparam logic [7:0]  CRC8_PRESET = 8'hFF;

	localparam int REG_UNMAPPED = 1;
	localparam logic [sfcc_pkg::ADDR_W-1:0] ADDR_CRC_CHECK_ENABLE =
		sfcc_pkg::ADDR_W'(4 * int'(sfcc_pkg::REG_CRC_CHECK_ENABLE));
	localparam logic [sfcc_pkg::ADDR_W-1:0] ADDR_UNMAPPED =
		sfcc_pkg::ADDR_W'(4 * REG_UNMAPPED);

	localparam int DIRECTED_ROWS   = 13;
	localparam int RANDOM_PHASES   = 6;
	localparam int FRAMES_PER_PHASE = 83;
	localparam int CYCLE_LIMIT     = 200000;

	logic                            clk;
	logic                            arst_n;
	logic                            s_tvalid;
	logic                            s_tready;
	// temp_raw [15:0], temp_check [23:16], humi_raw [39:24], humi_check [47:40].
	logic [sfcc_pkg::S_DATA_W-1:0]   s_tdata;
	logic                            m_tvalid;
	logic                            m_tready;
	// temp_centi [15:0], humi_centi [30:16], zero [31].
	logic [sfcc_pkg::M_DATA_W-1:0]   m_tdata;
	// temp_ok [0], humi_ok [1].
	logic [sfcc_pkg::M_USER_W-1:0]   m_tuser;
	logic                            psel;
	logic                            penable;
	logic                            pwrite;
	logic [sfcc_pkg::ADDR_W-1:0]     paddr;
	logic [31:0]                     pwdata;
	logic [31:0]                     prdata;
	logic                            pready;

	reading_t      expected_readings[$];
	directed_row_t directed_rows[DIRECTED_ROWS];
	logic          crc_check_on;
	int            tx_idle_pct;
	int            rx_idle_pct;
	int            mismatches;
	int            frames_sent;
	int            results_seen;
	int            cycle_count;

	sensor_frame_crc_convert uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// CRC-8 over the word, high byte first, one bit at a time from the top of each byte.
	function automatic logic [7:0] sensor_crc8(input logic [15:0] word);
		logic [7:0] crc;
		crc = CRC8_PRESET;
		for (int b = 1; b >= 0; b--) begin
			crc ^= word[8*b +: 8];
			for (int k = 0; k < 8; k++)
				crc = crc[7] ? ({crc[6:0], 1'b0} ^ CRC8_POLY) : {crc[6:0], 1'b0};
		end
		return crc;
	endfunction

	// Expected reading for one frame under the current checking mode.
	function automatic reading_t predict_reading(input frame_t f, input logic check_on);
		reading_t    r;
		int unsigned t_quot;
		int unsigned h_quot;
		r.temp_ok = !check_on || (sensor_crc8(f.temp_raw) == f.temp_check);
		r.humi_ok = !check_on || (sensor_crc8(f.humi_raw) == f.humi_check);
		t_quot = (f.temp_raw * TEMP_SPAN) / FULL_SCALE;
		h_quot = (f.humi_raw * HUMI_SPAN) / FULL_SCALE;
		r.temp_centi = r.temp_ok ? 16'(int'(t_quot) - TEMP_OFFSET) : 16'(TEMP_FAIL);
		r.humi_centi = r.humi_ok ? 15'(h_quot) : 15'(HUMI_FAIL);
		return r;
	endfunction

	function automatic directed_row_t stim_row(input logic on, input logic [15:0] traw,
			input logic [7:0] tchk, input logic [15:0] hraw, input logic [7:0] hchk,
			input logic typed, input int tc, input int hc, input logic tok, input logic hok);
		directed_row_t row;
		row.check_on           = on;
		row.frame.temp_raw     = traw;
		row.frame.temp_check   = tchk;
		row.frame.humi_raw     = hraw;
		row.frame.humi_check   = hchk;
		row.typed              = typed;
		row.reading.temp_centi = 16'(tc);
		row.reading.humi_centi = 15'(hc);
		row.reading.temp_ok    = tok;
		row.reading.humi_ok    = hok;
		return row;
	endfunction

	task automatic check_field(input string field, input int want, input int got);
		if (want != got) begin
			mismatches++;
			$error("%s: expected %0d, got %0d", field, want, got);
		end
	endtask

	// One APB transfer: setup phase, access phase, then the bus is left idle.
	task automatic apb_access(input logic write, input logic [sfcc_pkg::ADDR_W-1:0] addr,
			input logic [31:0] wdata, output logic [31:0] rdata);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= write;
		paddr   <= addr;
		pwdata  <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		if (write && addr == ADDR_CRC_CHECK_ENABLE)
			crc_check_on = wdata[0];
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain_results();
		while (expected_readings.size() != 0)
			@(posedge clk);
	endtask

	// Stops the input, lets the pipeline empty, then sets the checking mode and reads it back.
	task automatic set_check_mode(input logic on);
		logic [31:0] rd;
		s_tvalid <= 1'b0;
		drain_results();
		if ($urandom_range(1) == 1)
			apb_access(1'b1, ADDR_UNMAPPED, $urandom, rd);
		apb_access(1'b1, ADDR_CRC_CHECK_ENABLE, ($urandom & ~32'h1) | 32'(on), rd);
		apb_access(1'b0, ADDR_CRC_CHECK_ENABLE, 32'h0, rd);
		check_field("prdata", int'({31'b0, crc_check_on}), int'(rd));
	endtask

	// Offers one frame after a random gap and records its reading once the transfer is taken.
	task automatic send_frame(input frame_t f, input logic typed, input reading_t typed_r);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= f;
		do @(posedge clk); while (!s_tready);
		expected_readings.push_back(typed ? typed_r : predict_reading(f, crc_check_on));
		frames_sent++;
	endtask

	// Receiver back-pressure, redrawn every cycle.
	always @(posedge clk)
		m_tready <= ($urandom_range(99) >= rx_idle_pct);

	// Result checker: every output transfer is matched against the oldest expectation.
	always @(posedge clk) begin
		reading_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_readings.size() == 0) begin
				mismatches++;
				$error("result transfer with no frame outstanding: tdata %h tuser %b",
					m_tdata, m_tuser);
			end else begin
				want = expected_readings.pop_front();
				check_field("temp_centi", want.temp_centi, $signed(m_tdata[15:0]));
				check_field("humi_centi", want.humi_centi, $signed(m_tdata[30:16]));
				check_field("temp_ok", want.temp_ok, m_tuser[0]);
				check_field("humi_ok", want.humi_ok, m_tuser[1]);
				results_seen++;
			end
		end
	end

	// Watchdog on the whole run.
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Timeout after %0d cycles with %0d readings outstanding.",
			cycle_count, expected_readings.size());
		$display("simulation failed");
		$finish;
	end

	initial begin
		frame_t      f;
		logic [31:0] rd;
		reading_t    none;

		arst_n       = 1'b0;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		m_tready     = 1'b0;
		psel         = 1'b0;
		penable      = 1'b0;
		pwrite       = 1'b0;
		paddr        = '0;
		pwdata       = '0;
		crc_check_on = 1'b0;
		tx_idle_pct  = 11;
		rx_idle_pct  = 54;
		mismatches   = 0;
		frames_sent  = 0;
		results_seen = 0;
		none         = '0;

		// Extremes, ignored CRC bytes with checking off, then each pass and fail mix with it on.
		directed_rows = '{
			stim_row(1'b0, 16'h0000, 8'h00, 16'h0000, 8'h00, 1'b1, -4500, 0, 1'b1, 1'b1),
			stim_row(1'b0, 16'hFFFF, 8'hFF, 16'hFFFF, 8'hFF, 1'b1, 13000, 10000, 1'b1, 1'b1),
			stim_row(1'b0, 16'hFFFF, 8'h00, 16'h0000, 8'hFF, 1'b1, 13000, 0, 1'b1, 1'b1),
			stim_row(1'b0, 16'h8000, 8'hA5, 16'h7FFF, 8'h5A, 1'b0, 0, 0, 1'b0, 1'b0),
			stim_row(1'b0, 16'hBEEF, 8'h00, 16'h1234, 8'h00, 1'b0, 0, 0, 1'b0, 1'b0),
			stim_row(1'b1, 16'hBEEF, 8'h92, 16'hBEEF, 8'h92, 1'b0, 0, 0, 1'b0, 1'b0),
			stim_row(1'b1, 16'h0000, sensor_crc8(16'h0000), 16'hFFFF, sensor_crc8(16'hFFFF),
				1'b1, -4500, 10000, 1'b1, 1'b1),
			stim_row(1'b1, 16'hFFFF, sensor_crc8(16'hFFFF), 16'h0000, sensor_crc8(16'h0000),
				1'b1, 13000, 0, 1'b1, 1'b1),
			stim_row(1'b1, 16'hBEEF, 8'h93, 16'hBEEF, 8'h91,
				1'b1, TEMP_FAIL, HUMI_FAIL, 1'b0, 1'b0),
			stim_row(1'b1, 16'hBEEF, 8'h92, 16'h1234, sensor_crc8(16'h1234) ^ 8'h80,
				1'b0, 0, 0, 1'b0, 1'b0),
			stim_row(1'b1, 16'h5555, sensor_crc8(16'h5555) ^ 8'h01, 16'hAAAA,
				sensor_crc8(16'hAAAA), 1'b0, 0, 0, 1'b0, 1'b0),
			stim_row(1'b1, 16'h0000, sensor_crc8(16'h0000) ^ 8'hFF, 16'hFFFF,
				sensor_crc8(16'hFFFF) ^ 8'hFF, 1'b1, TEMP_FAIL, HUMI_FAIL, 1'b0, 1'b0),
			stim_row(1'b1, 16'h7FFF, sensor_crc8(16'h7FFF), 16'h8000, sensor_crc8(16'h8000),
				1'b0, 0, 0, 1'b0, 1'b0)
		};

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// The register must come out of reset with checking off.
		apb_access(1'b0, ADDR_CRC_CHECK_ENABLE, 32'h0, rd);
		check_field("prdata", 0, int'(rd));

		// Directed table; the mode is switched only where a row asks for another one.
		foreach (directed_rows[i]) begin
			if (directed_rows[i].check_on != crc_check_on)
				set_check_mode(directed_rows[i].check_on);
			send_frame(directed_rows[i].frame, directed_rows[i].typed,
				directed_rows[i].reading);
		end

		// Random frames, mostly with good CRC bytes, over each idling pattern and both modes.
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			case (phase / 2)
				0: begin
					tx_idle_pct = 11;
					rx_idle_pct = 54;
				end
				1: begin
					tx_idle_pct = 54;
					rx_idle_pct = 11;
				end
				default: begin
					tx_idle_pct = 0;
					rx_idle_pct = 0;
				end
			endcase
			set_check_mode(phase % 2 == 0);
			for (int n = 0; n < FRAMES_PER_PHASE; n++) begin
				f.temp_raw = ($urandom_range(15) == 0) ? {16{$urandom_range(1) == 1}}
					: 16'($urandom);
				f.humi_raw = ($urandom_range(15) == 0) ? {16{$urandom_range(1) == 1}}
					: 16'($urandom);
				f.temp_check = ($urandom_range(99) < 80) ? sensor_crc8(f.temp_raw)
					: 8'($urandom);
				f.humi_check = ($urandom_range(99) < 80) ? sensor_crc8(f.humi_raw)
					: 8'($urandom);
				send_frame(f, 1'b0, none);
			end
		end

		// Let the pipeline empty, then keep watching for anything stray to appear.
		s_tvalid <= 1'b0;
		drain_results();
		repeat (8) @(posedge clk);

		$display("Sent %0d frames (%0d from the directed table) and checked %0d readings,",
			frames_sent, DIRECTED_ROWS, results_seen);
		$display("with CRC checking on and off under three back-pressure patterns.");
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
